>>> sv/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/frti_pkg.sv
`default_nettype none
package frti_pkg;
  localparam int IndexBitsDefault = 10;
  localparam int FracBits = 23;
  localparam int WordBits = 64;

  typedef enum logic [1:0] {
    CMD_COMPUTE = 2'd0,
    CMD_WR_BASE = 2'd1,
    CMD_WR_GRAD = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_INTERP = 2'd0,
    KIND_FIXED  = 2'd1
  } kind_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic        sign;
    logic [7:0]  expo;
  } ctl_t;
endpackage
`default_nettype wire

>>> sv/float_reciprocal_table_interp.sv
// Reciprocal of a single-precision float by table interpolation.
// Channel in: command, operand_bits, table_index, table_word, taken at
// each rising edge with start high and busy low. busy is held low always,
// so one transaction is taken every clock cycle.
// Command 0 computes; 1 writes the base table; 2 writes the gradient
// table; 3 is dropped. Writes give no result.
// Channel out: result_bits is valid for exactly one cycle while done is
// high, after the compute transaction has passed through table read,
// multiplication, and subtract and round, each registered in turn.
// Throughput is one transaction per cycle, set by the single read port
// of each table memory. A write lands in the table before any later
// read of the same entry, so no interlock is needed.
// Reset clears the pipeline valids; table contents are undefined until
// written. The receiver cannot stall; every result must be taken.
`default_nettype none
`include "assert_macros.svh"
module float_reciprocal_table_interp #(
  parameter int INDEX_BITS = frti_pkg::IndexBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [31:0] operand_bits,
  input  wire logic [9:0]  table_index,
  input  wire logic [63:0] table_word,
  output logic             done,
  output logic      [31:0] result_bits
);
  localparam int LowBits = frti_pkg::FracBits - INDEX_BITS;
  localparam int Depth = 1 << INDEX_BITS;

  logic [63:0] base_mem [Depth];
  logic [63:0] grad_mem [Depth];

  logic                  acc;
  frti_pkg::cmd_t        cmd;
  logic [7:0]            expo;
  logic [22:0]           frac;
  logic [INDEX_BITS-1:0] rd_addr;
  logic [INDEX_BITS-1:0] wr_addr;
  frti_pkg::ctl_t        ctl_in;

  assign busy = 1'b0;
  assign acc = start && !busy;
  assign cmd = frti_pkg::cmd_t'(command);
  assign expo = operand_bits[30:23];
  assign frac = operand_bits[22:0];
  assign rd_addr = frac[22 -: INDEX_BITS];
  assign wr_addr = INDEX_BITS'(table_index);

  always_comb begin
    ctl_in.valid = acc && (cmd == frti_pkg::CMD_COMPUTE);
    ctl_in.sign = operand_bits[31];
    if (frac == 23'd0) begin
      ctl_in.kind = frti_pkg::KIND_FIXED;
      ctl_in.expo = 8'(8'd254 - expo);
    end else if (expo == 8'd0) begin
      ctl_in.kind = frti_pkg::KIND_FIXED;
      ctl_in.expo = 8'd255;
    end else if (expo == 8'd255) begin
      ctl_in.kind = frti_pkg::KIND_FIXED;
      ctl_in.expo = 8'd0;
    end else begin
      ctl_in.kind = frti_pkg::KIND_INTERP;
      ctl_in.expo = 8'(8'd253 - expo);
    end
  end

  logic [63:0]         base_rd;
  logic [63:0]         grad_rd;
  logic [LowBits-1:0]  lo1;
  frti_pkg::ctl_t      ctl1;
  frti_pkg::ctl_t      ctl2;
  logic [63:0]         base2;
  logic [63:0]         prod;

  always_ff @(posedge clk) begin
    if (acc && cmd == frti_pkg::CMD_WR_BASE) begin
      base_mem[wr_addr] <= table_word;
    end
    if (acc && cmd == frti_pkg::CMD_WR_GRAD) begin
      grad_mem[wr_addr] <= table_word;
    end
    base_rd <= base_mem[rd_addr];
    grad_rd <= grad_mem[rd_addr];
    lo1 <= frac[LowBits-1:0];
    base2 <= base_rd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1 <= '0;
      ctl2 <= '0;
    end else begin
      ctl1 <= ctl_in;
      ctl2 <= ctl1;
    end
  end

  frti_mul #(.LOW_BITS(LowBits)) u_mul (
    .clk  (clk),
    .rst  (rst),
    .en   (ctl1.valid),
    .lo   (lo1),
    .grad (grad_rd),
    .prod (prod)
  );

  logic [63:0] diff;
  logic [22:0] mant;
  assign diff = base2 - prod;
  assign mant = 23'(diff[56:34] + 23'(diff[33]));

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl2.valid;
    end
    result_bits <= {ctl2.sign, ctl2.expo,
                    (ctl2.kind == frti_pkg::KIND_INTERP) ? mant : 23'd0};
  end

  `ASSERT_NEXT(a_lat1, clk, rst, ctl_in.valid, ctl1.valid, "stage one lost")
  `ASSERT_NEXT(a_lat2, clk, rst, ctl2.valid, done, "result lost")
  `ASSERT_NEXT(a_nodup, clk, rst, !ctl2.valid, !done, "spurious result")
  `ASSERT_IMPLY(a_busy, clk, rst, 1'b1, !busy, "busy asserted")
endmodule
`default_nettype wire

>>> sv/frti_mul.sv
`default_nettype none
`include "assert_macros.svh"
module frti_mul #(
  parameter int LOW_BITS = 13
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic [LOW_BITS-1:0]   lo,
  input  wire logic [63:0]           grad,
  output logic      [63:0]           prod
);
  logic [31:0] p_low;
  logic [31:0] p_high;
  logic        en_d;

  always_ff @(posedge clk) begin
    p_low  <= 32'(grad[31:0] * 32'(lo));
    p_high <= 32'(grad[63:32] * 32'(lo));
    if (rst) begin
      en_d <= 1'b0;
    end else begin
      en_d <= en;
    end
  end

  logic [63:0] low_full;
  assign low_full = 64'(grad[31:0]) * 64'(lo);
  logic [31:0] p_carry;
  always_ff @(posedge clk) begin
    p_carry <= low_full[63:32];
  end

  assign prod = {32'(p_high + p_carry), p_low};

  `ASSERT_NEXT(a_en_follow, clk, rst, en, en_d, "multiplier enable not tracked")
  `ASSERT_IMPLY(a_en_known, clk, rst, 1'b1, !$isunknown(en), "enable unknown")
  `ASSERT_NEXT(a_en_drop, clk, rst, !en, !en_d, "multiplier enable spurious")
endmodule
`default_nettype wire
